// ===== hw/rtl/brss_pkg.sv =====
// Shared types, widths and codes for the burst receiver sample sequencer.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package brss_pkg;

	localparam int SAMPLE_WIDTH   = 12;
	localparam int THR_WIDTH      = 13;
	localparam int STEP_WIDTH     = 4;
	localparam int COUNT_WIDTH    = 12;
	localparam int ERR_WIDTH      = 4;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 13;
	// Three magnitudes of at most 2^(SAMPLE_WIDTH-1) fit in SAMPLE_WIDTH+1 bits.
	localparam int SUM_WIDTH      = SAMPLE_WIDTH + 1;
	localparam int CMP_WIDTH      = (SUM_WIDTH > THR_WIDTH) ? SUM_WIDTH : THR_WIDTH;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_DETECT_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_FULL_STEP        = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_HALF_STEP        = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PILOT_GROUPS     = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_FREQ_SAMPLES     = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PAYLOAD_LENGTH   = 3'd5;

	localparam logic [THR_WIDTH-1:0]   RST_DETECT_THRESHOLD = 13'd1300;
	localparam logic [STEP_WIDTH-1:0]  RST_FULL_STEP        = 4'd8;
	localparam logic [STEP_WIDTH-1:0]  RST_HALF_STEP        = 4'd4;
	localparam logic [STEP_WIDTH-1:0]  RST_PILOT_GROUPS     = 4'd8;
	localparam logic [STEP_WIDTH-1:0]  RST_FREQ_SAMPLES     = 4'd2;
	localparam logic [COUNT_WIDTH-1:0] RST_PAYLOAD_LENGTH   = 12'd768;

	localparam logic [1:0] TRIG_NONE = 2'd0;
	localparam logic [1:0] TRIG_I    = 2'd1;
	localparam logic [1:0] TRIG_Q    = 2'd2;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_ERROR = 2'd1,
		REQ_ARM   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		PH_DETECT  = 2'd0,
		PH_TIMING  = 2'd1,
		PH_FREQ    = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_DETECT  = 3'd1,
		MODE_TIMING  = 3'd2,
		MODE_WAIT    = 3'd3,
		MODE_FREQ    = 3'd4,
		MODE_PAYLOAD = 3'd5
	} mode_t;

	typedef struct packed {
		logic [THR_WIDTH-1:0]   detect_threshold;
		logic [STEP_WIDTH-1:0]  full_step;
		logic [STEP_WIDTH-1:0]  half_step;
		logic [STEP_WIDTH-1:0]  pilot_groups;
		logic [STEP_WIDTH-1:0]  freq_samples;
		logic [COUNT_WIDTH-1:0] payload_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]                     req_type;
		logic signed [SAMPLE_WIDTH-1:0] i_sample;
		logic signed [SAMPLE_WIDTH-1:0] q_sample;
		logic signed [ERR_WIDTH-1:0]    timing_error;
	} item_t;

	typedef struct packed {
		logic [1:0]                     phase;
		logic signed [SAMPLE_WIDTH-1:0] i_value;
		logic signed [SAMPLE_WIDTH-1:0] q_value;
		logic [1:0]                     trigger_channel;
		logic [COUNT_WIDTH-1:0]         sequence_index;
		logic                           awaits_error;
		logic                           step_clamped;
		logic                           last;
	} result_t;

endpackage

// ===== hw/rtl/brss_cfg_regs.sv =====
// Configuration register bank of the sample sequencer.
// Depends on brss_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module brss_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [brss_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [brss_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output brss_pkg::cfg_t                       cfg
);
	import brss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_threshold <= RST_DETECT_THRESHOLD;
			cfg_q.full_step        <= RST_FULL_STEP;
			cfg_q.half_step        <= RST_HALF_STEP;
			cfg_q.pilot_groups     <= RST_PILOT_GROUPS;
			cfg_q.freq_samples     <= RST_FREQ_SAMPLES;
			cfg_q.payload_length   <= RST_PAYLOAD_LENGTH;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DETECT_THRESHOLD: cfg_q.detect_threshold <= cfg_data[THR_WIDTH-1:0];
				CFG_FULL_STEP:        cfg_q.full_step        <= cfg_data[STEP_WIDTH-1:0];
				CFG_HALF_STEP:        cfg_q.half_step        <= cfg_data[STEP_WIDTH-1:0];
				CFG_PILOT_GROUPS:     cfg_q.pilot_groups     <= cfg_data[STEP_WIDTH-1:0];
				CFG_FREQ_SAMPLES:     cfg_q.freq_samples     <= cfg_data[STEP_WIDTH-1:0];
				CFG_PAYLOAD_LENGTH:   cfg_q.payload_length   <= cfg_data[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/brss_in_reg.sv =====
// Input register stage: holds one accepted item until the sequencer takes it.
// Depends on brss_pkg for item_t.
`timescale 1ns / 1ps

module brss_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  brss_pkg::item_t in_item,
	input  logic            take,
	output logic            valid_s1,
	output brss_pkg::item_t item_s1
);
	import brss_pkg::*;

	logic  vld_s1;
	item_t data_s1;

	// The stage refills in the same cycle in which its item moves on.
	assign in_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_item;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = data_s1;

endmodule

// ===== hw/rtl/brss_seq.sv =====
// Burst sequencer core: detection window, tick spacing, phase counters and
// result formation for one item per cycle while proc is high. Depends on brss_pkg.
`timescale 1ns / 1ps

module brss_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  brss_pkg::cfg_t    cfg,
	input  logic              proc,
	input  brss_pkg::item_t   item,
	output logic              res_valid,
	output brss_pkg::result_t res
);
	import brss_pkg::*;

	function automatic logic [SAMPLE_WIDTH-1:0] mag(input logic signed [SAMPLE_WIDTH-1:0] v);
		mag = v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-v) : SAMPLE_WIDTH'(v);
	endfunction

	mode_t                          mode_q, mode_d;
	logic [STEP_WIDTH-1:0]          tick_q, tick_d;
	logic [STEP_WIDTH-1:0]          spacing_q, spacing_d;
	logic [COUNT_WIDTH-1:0]         count_q, count_d;
	logic [1:0]                     group_q, group_d;
	logic [1:0]                     wfill_q, wfill_d;
	logic [1:0]                     trig_q, trig_d;
	logic                           clamp_q, clamp_d;
	logic signed [SAMPLE_WIDTH-1:0] win_i_q [2];
	logic signed [SAMPLE_WIDTH-1:0] win_q_q [2];
	logic signed [SAMPLE_WIDTH-1:0] win_i_d [2];
	logic signed [SAMPLE_WIDTH-1:0] win_q_d [2];

	logic [STEP_WIDTH-1:0]  tick_inc;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [CMP_WIDTH-1:0]   sum_i, sum_q, thr;
	logic                   hit_i, hit_q;
	logic                   tick_event;
	logic                   win_full;
	logic signed [5:0]      new_spacing;

	assign tick_inc  = tick_q + 1'b1;
	assign count_inc = count_q + 1'b1;
	assign win_full  = wfill_q[1];

	assign sum_i = CMP_WIDTH'(mag(win_i_q[0])) + CMP_WIDTH'(mag(win_i_q[1]))
		+ CMP_WIDTH'(mag(item.i_sample));
	assign sum_q = CMP_WIDTH'(mag(win_q_q[0])) + CMP_WIDTH'(mag(win_q_q[1]))
		+ CMP_WIDTH'(mag(item.q_sample));
	assign thr   = CMP_WIDTH'(cfg.detect_threshold);
	assign hit_i = sum_i > thr;
	assign hit_q = sum_q > thr;

	// Spacing after a timing group: full step less the reported error.
	assign new_spacing = $signed({2'b00, cfg.full_step})
		- $signed({{2{item.timing_error[ERR_WIDTH-1]}}, item.timing_error});

	// A tick counts only in an active phase, and fires once the spacing is met.
	assign tick_event = proc && (item.req_type == REQ_TICK) && (mode_q != MODE_IDLE)
		&& (mode_q != MODE_WAIT) && (tick_inc >= spacing_q);

	assign res_valid = tick_event && ((mode_q != MODE_DETECT) || (win_full && (hit_i || hit_q)));

	// Next state.
	always_comb begin
		mode_d     = mode_q;
		tick_d     = tick_q;
		spacing_d  = spacing_q;
		count_d    = count_q;
		group_d    = group_q;
		wfill_d    = wfill_q;
		trig_d     = trig_q;
		clamp_d    = clamp_q;
		win_i_d    = win_i_q;
		win_q_d    = win_q_q;
		if (proc) begin
			case (item.req_type)
				REQ_ARM: begin
					mode_d    = MODE_DETECT;
					tick_d    = '0;
					spacing_d = STEP_WIDTH'(1);
					count_d   = '0;
					group_d   = '0;
					wfill_d   = '0;
					trig_d    = TRIG_NONE;
					clamp_d   = 1'b0;
				end
				REQ_ERROR: begin
					if (mode_q == MODE_WAIT) begin
						tick_d  = '0;
						clamp_d = new_spacing < 6'sd1;
						if (new_spacing < 6'sd1) begin
							spacing_d = STEP_WIDTH'(1);
						end else if (new_spacing > 6'sd15) begin
							spacing_d = STEP_WIDTH'(15);
						end else begin
							spacing_d = new_spacing[STEP_WIDTH-1:0];
						end
						if (count_inc == COUNT_WIDTH'(cfg.pilot_groups)) begin
							count_d = '0;
							mode_d  = MODE_FREQ;
						end else begin
							count_d = count_inc;
							mode_d  = MODE_TIMING;
						end
					end
				end
				REQ_TICK: begin
					if (mode_q != MODE_IDLE && mode_q != MODE_WAIT) begin
						tick_d = tick_inc;
						if (tick_inc >= spacing_q) begin
							tick_d = '0;
							case (mode_q)
								MODE_DETECT: begin
									if (!win_full) begin
										win_i_d[wfill_q[0]] = item.i_sample;
										win_q_d[wfill_q[0]] = item.q_sample;
										wfill_d             = wfill_q + 1'b1;
									end else if (hit_i || hit_q) begin
										trig_d    = hit_i ? TRIG_I : TRIG_Q;
										mode_d    = MODE_TIMING;
										spacing_d = STEP_WIDTH'(1);
										count_d   = '0;
										group_d   = '0;
										wfill_d   = '0;
									end else begin
										win_i_d[0] = win_i_q[1];
										win_i_d[1] = item.i_sample;
										win_q_d[0] = win_q_q[1];
										win_q_d[1] = item.q_sample;
									end
								end
								MODE_TIMING: begin
									clamp_d   = 1'b0;
									spacing_d = cfg.half_step;
									if (group_q == 2'd2) begin
										group_d = '0;
										mode_d  = MODE_WAIT;
									end else begin
										group_d = group_q + 1'b1;
									end
								end
								MODE_FREQ: begin
									clamp_d   = 1'b0;
									spacing_d = cfg.full_step;
									if (count_inc == COUNT_WIDTH'(cfg.freq_samples)) begin
										count_d = '0;
										mode_d  = MODE_PAYLOAD;
									end else begin
										count_d = count_inc;
									end
								end
								MODE_PAYLOAD: begin
									clamp_d   = 1'b0;
									spacing_d = cfg.full_step;
									count_d   = count_inc;
									// The last payload sample ends the burst; re-arming is needed.
									if (count_inc == cfg.payload_length) begin
										mode_d    = MODE_IDLE;
										spacing_d = STEP_WIDTH'(1);
										count_d   = '0;
										group_d   = '0;
										wfill_d   = '0;
										trig_d    = TRIG_NONE;
									end
								end
								default: ;
							endcase
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields.
	always_comb begin
		res.i_value         = item.i_sample;
		res.q_value         = item.q_sample;
		res.trigger_channel = trig_q;
		res.sequence_index  = count_q;
		res.awaits_error    = 1'b0;
		res.step_clamped    = clamp_q;
		res.last            = 1'b0;
		case (mode_q)
			MODE_DETECT: begin
				res.phase           = PH_DETECT;
				res.trigger_channel = hit_i ? TRIG_I : TRIG_Q;
				res.sequence_index  = '0;
				res.step_clamped    = 1'b0;
			end
			MODE_TIMING: begin
				res.phase        = PH_TIMING;
				res.awaits_error = group_q == 2'd2;
			end
			MODE_FREQ: begin
				res.phase = PH_FREQ;
			end
			MODE_PAYLOAD: begin
				res.phase = PH_PAYLOAD;
				res.last  = count_inc == cfg.payload_length;
			end
			default: begin
				res.phase = PH_DETECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			tick_q    <= '0;
			spacing_q <= STEP_WIDTH'(1);
			count_q   <= '0;
			group_q   <= '0;
			wfill_q   <= '0;
			trig_q    <= TRIG_NONE;
			clamp_q   <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			tick_q    <= tick_d;
			spacing_q <= spacing_d;
			count_q   <= count_d;
			group_q   <= group_d;
			wfill_q   <= wfill_d;
			trig_q    <= trig_d;
			clamp_q   <= clamp_d;
		end
	end

	// The window is only read once both entries have been written.
	always_ff @(posedge clk) begin
		win_i_q <= win_i_d;
		win_q_q <= win_q_d;
	end

`ifndef NO_ASSERTIONS
	a_group_range: assert property (@(posedge clk) disable iff (!arst_n)
		group_q != 2'd3)
		else $error("timing group fill out of range");

	a_awaits_timing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.awaits_error |=> mode_q == MODE_WAIT)
		else $error("group close did not enter the error wait");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |=> mode_q == MODE_IDLE && trig_q == TRIG_NONE)
		else $error("burst did not end after the last payload item");

	a_clamp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		clamp_q |-> (mode_q == MODE_TIMING || mode_q == MODE_FREQ))
		else $error("clamp flag pending outside timing or frequency phase");
`endif

endmodule

// ===== hw/rtl/brss_out_reg.sv =====
// Result register: holds one result item until the consumer takes it.
// Depends on brss_pkg for result_t.
`timescale 1ns / 1ps

module brss_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  brss_pkg::result_t res_in,
	output logic              load_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output brss_pkg::result_t res_out
);
	import brss_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign load_ok = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

// ===== hw/rtl/burst_receiver_sample_sequencer.sv =====
// Burst receiver sample sequencer, top level. An accepted item is registered in
// the input register, and its result item, if any, in the result register.
// Throughput: one item per cycle; a stalled result register holds the input
// stage. Reset (arst_n, asynchronous, active low) restores the register defaults
// and leaves the sequencer idle and not armed.
// Depends on brss_pkg, brss_cfg_regs, brss_in_reg, brss_seq and brss_out_reg.
`timescale 1ns / 1ps

module burst_receiver_sample_sequencer (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_write,
	input  logic [brss_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
	input  logic [brss_pkg::CFG_DATA_WIDTH-1:0]        cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [1:0]                                 req_type,
	input  logic signed [brss_pkg::SAMPLE_WIDTH-1:0]   i_sample,
	input  logic signed [brss_pkg::SAMPLE_WIDTH-1:0]   q_sample,
	input  logic signed [brss_pkg::ERR_WIDTH-1:0]      timing_error,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [1:0]                                 phase,
	output logic signed [brss_pkg::SAMPLE_WIDTH-1:0]   i_value,
	output logic signed [brss_pkg::SAMPLE_WIDTH-1:0]   q_value,
	output logic [1:0]                                 trigger_channel,
	output logic [brss_pkg::COUNT_WIDTH-1:0]           sequence_index,
	output logic                                       awaits_error,
	output logic                                       step_clamped,
	output logic                                       last
);
	import brss_pkg::*;

	cfg_t    cfg;
	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    load_ok;
	logic    proc;
	logic    res_valid;
	result_t res;
	result_t res_out;

	assign in_item.req_type     = req_type;
	assign in_item.i_sample     = i_sample;
	assign in_item.q_sample     = q_sample;
	assign in_item.timing_error = timing_error;

	// An item is worked on only when its result, if any, has a place to go.
	assign proc = valid_s1 && load_ok;

	brss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	brss_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (proc),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	brss_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.proc      (proc),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	brss_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_in    (res),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign phase           = res_out.phase;
	assign i_value         = res_out.i_value;
	assign q_value         = res_out.q_value;
	assign trigger_channel = res_out.trigger_channel;
	assign sequence_index  = res_out.sequence_index;
	assign awaits_error    = res_out.awaits_error;
	assign step_clamped    = res_out.step_clamped;
	assign last            = res_out.last;

endmodule
